// ===== sv/kds_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kds_pkg
// shared types, codes and constants of the keyframe displacement sampler
// ----------------------------------------------------------------------------
package kds_pkg;

    // table size default and fixed data widths
    localparam int unsigned MAX_FRAMES_DEF = 1024;
    localparam int unsigned DATA_W         = 32;
    localparam int unsigned FPS_W          = 10;
    localparam int unsigned ALPHA_W        = 16;
    localparam int unsigned POS_W          = 42;
    localparam int unsigned LANES          = 6;

    // divide-by-1000 unit: reciprocal multiply with one correction step
    localparam int unsigned            DIV_NW = 26;
    localparam int unsigned            DIV_KW = 17;
    localparam int unsigned            DIV_QW = 17;
    localparam int unsigned            DIV_RW = 10;
    localparam logic [DIV_RW-1:0]      DIVISOR = 10'd1000;
    localparam logic [DIV_KW-1:0]      DIV_K  = DIV_KW'((64'd1 << DIV_NW) / 64'd1000);

    localparam logic [DATA_W-1:0]      Q_MIN   = 32'h8000_0000;
    localparam logic [FPS_W-1:0]       FPS_RST = 10'd30;

    // register index
    localparam logic REG_IDX_FPS = 1'b0;

    // opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic               opcode;
        logic               restart;
        logic signed [31:0] dummy_x;
        logic signed [31:0] dummy_y;
        logic signed [31:0] dummy_z;
        logic signed [31:0] pelvis_x;
        logic signed [31:0] pelvis_y;
        logic        [31:0] time_ms;
    } item_t;

    typedef struct packed {
        logic        [1:0]  status;
        logic signed [31:0] phys_out_x;
        logic signed [31:0] phys_out_y;
        logic signed [31:0] phys_out_z;
        logic signed [31:0] offset_out_x;
        logic signed [31:0] offset_out_y;
        logic signed [31:0] offset_out_z;
    } result_t;

    typedef struct packed {
        logic               wr_en;
        logic               rd_en;
        logic [ALPHA_W-1:0] alpha;
    } lane_ctl_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPEND,
        S_QMUL,
        S_QDIV1,
        S_QWAIT1,
        S_QWAIT2,
        S_READ,
        S_LERP,
        S_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== sv/kds_div1000.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kds_div1000
// staged divide by 1000 of a 26-bit value; the later stages reuse the dividend register
// ----------------------------------------------------------------------------
module kds_div1000
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [kds_pkg::DIV_NW-1:0]  n,
    output logic                             done,
    output logic      [kds_pkg::DIV_QW-1:0]  q,
    output logic      [kds_pkg::DIV_RW-1:0]  r
);

    localparam int unsigned PW = kds_pkg::DIV_NW + kds_pkg::DIV_KW;
    localparam int unsigned CW = kds_pkg::DIV_NW + 1;

    logic [kds_pkg::DIV_NW-1:0] n_reg;
    logic [kds_pkg::DIV_QW-1:0] qe_reg;
    logic [kds_pkg::DIV_RW:0]   r0_reg;
    logic [kds_pkg::DIV_QW-1:0] q_reg;
    logic [kds_pkg::DIV_RW-1:0] r_reg;
    logic                       s1_reg;
    logic                       s2_reg;
    logic                       s3_reg;
    logic                       done_reg;

    logic [PW-1:0] prod;
    logic [CW-1:0] back;
    logic [CW-1:0] diff;
    logic          over;

    // estimate never exceeds the true quotient and is at most one below it
    assign prod = PW'(n_reg) * PW'(kds_pkg::DIV_K);
    assign back = CW'(qe_reg) * CW'(kds_pkg::DIVISOR);
    assign diff = CW'(n_reg) - back;
    assign over = (r0_reg >= (kds_pkg::DIV_RW + 1)'(kds_pkg::DIVISOR));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            s3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= start;
            s2_reg   <= s1_reg;
            s3_reg   <= s2_reg;
            done_reg <= s3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= n;
        end
        if (s1_reg)
        begin
            qe_reg <= prod[kds_pkg::DIV_NW +: kds_pkg::DIV_QW];
        end
        if (s2_reg)
        begin
            r0_reg <= diff[kds_pkg::DIV_RW:0];
        end
        if (s3_reg)
        begin
            if (over)
            begin
                q_reg <= qe_reg + kds_pkg::DIV_QW'(1);
                r_reg <= kds_pkg::DIV_RW'(r0_reg - (kds_pkg::DIV_RW + 1)'(kds_pkg::DIVISOR));
            end
            else
            begin
                q_reg <= qe_reg;
                r_reg <= r0_reg[kds_pkg::DIV_RW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;
    assign r    = r_reg;

    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (r_reg < kds_pkg::DIVISOR))
        else $error("divider remainder out of range");

    a_quot_exact: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ((CW'(q_reg) * CW'(kds_pkg::DIVISOR) + CW'(r_reg)) == CW'(n_reg)))
        else $error("divider quotient and remainder do not rebuild the dividend");

endmodule

`default_nettype wire

// ===== sv/kds_lane.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kds_lane
// one axis: keyframe memory with two read ports and a linear interpolator
// ----------------------------------------------------------------------------
module kds_lane
#(
    parameter int unsigned DEPTH = kds_pkg::MAX_FRAMES_DEF,
    parameter int unsigned AW    = $clog2(kds_pkg::MAX_FRAMES_DEF)
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kds_pkg::lane_ctl_t   ctl,
    input  wire logic [AW-1:0]        wr_addr,
    input  wire logic [31:0]          wr_data,
    input  wire logic [AW-1:0]        rd_addr0,
    input  wire logic [AW-1:0]        rd_addr1,
    output logic      [31:0]          res,
    output logic                      res_valid
);

    logic [31:0] mem [DEPTH];

    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        a2_reg;
    logic signed [49:0] p_reg;
    logic [31:0]        out_reg;
    logic               v1_reg;
    logic               v2_reg;
    logic               v3_reg;

    logic signed [32:0] diff;
    logic signed [16:0] alpha_s;
    logic signed [49:0] p_next;

    assign diff    = $signed({b_reg[31], b_reg}) - $signed({a_reg[31], a_reg});
    assign alpha_s = $signed({1'b0, ctl.alpha});
    assign p_next  = diff * alpha_s;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            a_reg <= mem[rd_addr0];
            b_reg <= mem[rd_addr1];
        end
    end

    // floor of p / 65536 is the arithmetic shift, only the low 32 bits survive
    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            p_reg  <= p_next;
            a2_reg <= a_reg;
        end
        if (v2_reg)
        begin
            out_reg <= a2_reg + p_reg[47:16];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= ctl.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign res       = out_reg;
    assign res_valid = v3_reg;

    a_lane_latency: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en |-> ##3 res_valid)
        else $error("lane result did not follow the read");

endmodule

`default_nettype wire

// ===== sv/keyframe_displacement_sampler_unit.sv =====
`default_nettype none
// append: the transaction passes S_APPEND and S_EMIT, next item taken once the result is loaded
// query: one pass through the shared divide-by-1000 unit when clamped to the last keyframe,
//   two otherwise, then the lane read and blend before S_EMIT
// empty-table query: S_QMUL straight to S_EMIT; one item in flight, one finished result may wait
// reset: frame count 0, rate 30 frames/s, keyframe memories are not cleared
// ----------------------------------------------------------------------------
// keyframe_displacement_sampler_unit
// keyframe table with six axis lanes, interpolated lookup by millisecond time
// ----------------------------------------------------------------------------
module keyframe_displacement_sampler_unit
#(
    parameter int unsigned MAX_FRAMES = kds_pkg::MAX_FRAMES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // item channel
    input  wire logic             item_valid,
    output logic                  item_ready,
    input  wire kds_pkg::item_t   item,
    // result channel
    output logic                  result_valid,
    input  wire logic             result_ready,
    output kds_pkg::result_t      result,
    // configuration port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output logic      [31:0]      prdata,
    output logic                  pready
);

    // address width of the tables and width of the fill count
    localparam int unsigned IW  = $clog2(MAX_FRAMES);
    localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned LKW = IW + kds_pkg::FPS_W;
    localparam int unsigned PW  = kds_pkg::POS_W;
    localparam int unsigned NW  = kds_pkg::DIV_NW;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [kds_pkg::FPS_W-1:0] fps_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fps_reg <= kds_pkg::FPS_RST;
        end
        else if (psel && penable && pwrite && (paddr[2] == kds_pkg::REG_IDX_FPS))
        begin
            fps_reg <= pwdata[kds_pkg::FPS_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == kds_pkg::REG_IDX_FPS)
        begin
            prdata = {{(32 - kds_pkg::FPS_W){1'b0}}, fps_reg};
        end
        else
        begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // control state and datapath registers
    // ------------------------------------------------------------------
    kds_pkg::state_t  state_reg;
    kds_pkg::state_t  state_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    kds_pkg::item_t   item_reg;
    kds_pkg::result_t res_reg;
    kds_pkg::result_t res_next;
    kds_pkg::result_t result_reg;
    logic             result_valid_reg;
    logic             load_result;

    logic [PW-1:0]    pos_reg;        // time_ms * frames_per_second, exact
    logic [LKW-1:0]   lastk_reg;      // last index * 1000
    logic [IW-1:0]    last_reg;
    logic             clamp_reg;      // position at or past the last keyframe
    logic [IW-1:0]    i0_reg;
    logic [IW-1:0]    i1_reg;
    logic [kds_pkg::ALPHA_W-1:0] alpha_reg;

    // divider hookup
    logic                        div_start;
    logic [NW-1:0]               div_n;
    logic                        div_done;
    logic [kds_pkg::DIV_QW-1:0]  div_q;
    logic [kds_pkg::DIV_RW-1:0]  div_r;

    // lanes: phys x, y, z then offset x, y, z
    kds_pkg::lane_ctl_t          lane_ctl;
    logic [31:0]                 lane_wdata [kds_pkg::LANES];
    logic [31:0]                 lane_res   [kds_pkg::LANES];
    logic [kds_pkg::LANES-1:0]   lane_valid;

    // ------------------------------------------------------------------
    // append arithmetic: axis swap (x, y, z) -> (-y, x, z), offset is
    // converted pelvis with z forced to zero minus the physical vector
    // ------------------------------------------------------------------
    logic signed [32:0] off_x_wide;
    logic signed [32:0] off_y_wide;
    logic               ovf;
    logic [CW-1:0]      count_eff;
    logic [IW-1:0]      last_w;

    assign off_x_wide = {item_reg.dummy_y[31], item_reg.dummy_y}
                      - {item_reg.pelvis_y[31], item_reg.pelvis_y};
    assign off_y_wide = {item_reg.pelvis_x[31], item_reg.pelvis_x}
                      - {item_reg.dummy_x[31], item_reg.dummy_x};

    // negating the most negative value and a wrapped difference both overflow
    assign ovf = (item_reg.dummy_y == kds_pkg::Q_MIN)
              || (item_reg.dummy_z == kds_pkg::Q_MIN)
              || (off_x_wide[32] != off_x_wide[31])
              || (off_y_wide[32] != off_y_wide[31]);

    assign lane_wdata[0] = 32'(-item_reg.dummy_y);
    assign lane_wdata[1] = item_reg.dummy_x;
    assign lane_wdata[2] = item_reg.dummy_z;
    assign lane_wdata[3] = off_x_wide[31:0];
    assign lane_wdata[4] = off_y_wide[31:0];
    assign lane_wdata[5] = 32'(-item_reg.dummy_z);

    // restart empties the table before the new frame is stored
    assign count_eff = item_reg.restart ? '0 : count_reg;
    assign last_w    = IW'(count_reg - CW'(1));

    // first pass divides the position, second pass turns the remainder
    // into a 16-bit blend weight
    assign div_n = (state_reg == kds_pkg::S_QDIV1) ? pos_reg[NW-1:0]
                                                   : {div_r, {kds_pkg::ALPHA_W{1'b0}}};

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        item_ready     = 1'b0;
        div_start      = 1'b0;
        load_result    = 1'b0;
        lane_ctl.wr_en = 1'b0;
        lane_ctl.rd_en = 1'b0;
        lane_ctl.alpha = alpha_reg;

        case (state_reg)
            kds_pkg::S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    state_next = (item.opcode == kds_pkg::OP_QUERY) ? kds_pkg::S_QMUL
                                                                    : kds_pkg::S_APPEND;
                end
            end
            kds_pkg::S_APPEND:
            begin
                res_next = '0;
                if (ovf)
                begin
                    count_next      = '0;
                    res_next.status = kds_pkg::ST_OVF;
                end
                else if (count_eff == CW'(MAX_FRAMES))
                begin
                    count_next      = count_eff;
                    res_next.status = kds_pkg::ST_FULL;
                end
                else
                begin
                    lane_ctl.wr_en  = 1'b1;
                    count_next      = count_eff + CW'(1);
                    res_next.status = kds_pkg::ST_OK;
                end
                state_next = kds_pkg::S_EMIT;
            end
            kds_pkg::S_QMUL:
            begin
                if (count_reg == '0)
                begin
                    res_next        = '0;
                    res_next.status = kds_pkg::ST_EMPTY;
                    state_next      = kds_pkg::S_EMIT;
                end
                else
                begin
                    state_next = kds_pkg::S_QDIV1;
                end
            end
            kds_pkg::S_QDIV1:
            begin
                div_start  = 1'b1;
                state_next = kds_pkg::S_QWAIT1;
            end
            kds_pkg::S_QWAIT1:
            begin
                if (div_done)
                begin
                    if (clamp_reg)
                    begin
                        state_next = kds_pkg::S_READ;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = kds_pkg::S_QWAIT2;
                    end
                end
            end
            kds_pkg::S_QWAIT2:
            begin
                if (div_done)
                begin
                    state_next = kds_pkg::S_READ;
                end
            end
            kds_pkg::S_READ:
            begin
                lane_ctl.rd_en = 1'b1;
                state_next     = kds_pkg::S_LERP;
            end
            kds_pkg::S_LERP:
            begin
                if (lane_valid[0])
                begin
                    // merge the six lane outputs into one result transaction
                    res_next.status       = kds_pkg::ST_OK;
                    res_next.phys_out_x   = lane_res[0];
                    res_next.phys_out_y   = lane_res[1];
                    res_next.phys_out_z   = lane_res[2];
                    res_next.offset_out_x = lane_res[3];
                    res_next.offset_out_y = lane_res[4];
                    res_next.offset_out_z = lane_res[5];
                    state_next            = kds_pkg::S_EMIT;
                end
            end
            kds_pkg::S_EMIT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_result = 1'b1;
                    state_next  = kds_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = kds_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kds_pkg::S_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (load_result)
        begin
            result_reg <= res_reg;
        end
        if (state_reg == kds_pkg::S_QMUL)
        begin
            pos_reg   <= PW'(item_reg.time_ms) * PW'(fps_reg);
            lastk_reg <= LKW'(last_w) * LKW'(kds_pkg::DIVISOR);
            last_reg  <= last_w;
        end
        if (state_reg == kds_pkg::S_QDIV1)
        begin
            clamp_reg <= (pos_reg >= PW'(lastk_reg));
        end
        if ((state_reg == kds_pkg::S_QWAIT1) && div_done)
        begin
            if (clamp_reg)
            begin
                // hold the last keyframe exactly
                i0_reg    <= last_reg;
                i1_reg    <= last_reg;
                alpha_reg <= '0;
            end
            else
            begin
                i0_reg <= div_q[IW-1:0];
                i1_reg <= div_q[IW-1:0] + IW'(1);
            end
        end
        if ((state_reg == kds_pkg::S_QWAIT2) && div_done)
        begin
            alpha_reg <= div_q[kds_pkg::ALPHA_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // shared divider and the six axis lanes
    // ------------------------------------------------------------------
    kds_div1000 u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .n     (div_n),
        .done  (div_done),
        .q     (div_q),
        .r     (div_r)
    );

    for (genvar g = 0; g < kds_pkg::LANES; g++)
    begin : g_lane
        kds_lane
        #(
            .DEPTH (MAX_FRAMES),
            .AW    (IW)
        )
        u_lane
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (lane_ctl),
            .wr_addr   (count_eff[IW-1:0]),
            .wr_data   (lane_wdata[g]),
            .rd_addr0  (i0_reg),
            .rd_addr1  (i1_reg),
            .res       (lane_res[g]),
            .res_valid (lane_valid[g])
        );
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_FRAMES))
        else $error("frame count past table size");

    a_clamp_read: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_ctl.rd_en && clamp_reg) |-> ((alpha_reg == '0) && (i0_reg == i1_reg)))
        else $error("clamped lookup must read one keyframe with zero weight");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_valid == '0) || (lane_valid == '1))
        else $error("axis lanes out of step");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && (result_reg.status == kds_pkg::ST_EMPTY))
        |-> ((result_reg.phys_out_x == '0) && (result_reg.phys_out_y == '0)
          && (result_reg.phys_out_z == '0) && (result_reg.offset_out_x == '0)
          && (result_reg.offset_out_y == '0) && (result_reg.offset_out_z == '0)))
        else $error("empty-table result carries nonzero vectors");

endmodule

`default_nettype wire
